// File: hdl/wlcm_pkg.sv
package wlcm_pkg;

   localparam int unsigned COMP_W    = 24;
   localparam int unsigned LIMIT_W   = 23;
   localparam int unsigned SQ_W      = 2 * COMP_W;
   localparam int unsigned LIM_SQ_W  = 2 * LIMIT_W;
   localparam int unsigned CNT_W     = 8;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned NUM_COMP  = 6;

   // Reset limits, LSB 1/1024 N or N.m.
   localparam logic [LIMIT_W-1:0] FORCE_LIMIT_USER_RST    = 23'd51200;
   localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_USER_RST   = 23'd5120;
   localparam logic [LIMIT_W-1:0] FORCE_LIMIT_BIASED_RST  = 23'd10240;
   localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_BIASED_RST = 23'd819;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIAS_ENABLED        = 3'd0,
      CSR_FORCE_LIMIT_USER    = 3'd1,
      CSR_TORQUE_LIMIT_USER   = 3'd2,
      CSR_FORCE_LIMIT_BIASED  = 3'd3,
      CSR_TORQUE_LIMIT_BIASED = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic               bias_enabled;
      logic [LIMIT_W-1:0] force_limit_user;
      logic [LIMIT_W-1:0] torque_limit_user;
      logic [LIMIT_W-1:0] force_limit_biased;
      logic [LIMIT_W-1:0] torque_limit_biased;
   } cfg_type;

endpackage

// File: hdl/wlcm_csr.sv
module wlcm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wlcm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wlcm_pkg::LIMIT_W-1:0]     csr_data,
   output wlcm_pkg::cfg_type                cfg
);

   wlcm_pkg::cfg_type cfg_ff;
   wlcm_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (wlcm_pkg::csr_index_type'(csr_index))
            wlcm_pkg::CSR_BIAS_ENABLED:        cfg_in.bias_enabled        = csr_data[0];
            wlcm_pkg::CSR_FORCE_LIMIT_USER:    cfg_in.force_limit_user    = csr_data;
            wlcm_pkg::CSR_TORQUE_LIMIT_USER:   cfg_in.torque_limit_user   = csr_data;
            wlcm_pkg::CSR_FORCE_LIMIT_BIASED:  cfg_in.force_limit_biased  = csr_data;
            wlcm_pkg::CSR_TORQUE_LIMIT_BIASED: cfg_in.torque_limit_biased = csr_data;
            // Writes to unused indices are dropped.
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bias_enabled        <= 1'b0;
         cfg_ff.force_limit_user    <= wlcm_pkg::FORCE_LIMIT_USER_RST;
         cfg_ff.torque_limit_user   <= wlcm_pkg::TORQUE_LIMIT_USER_RST;
         cfg_ff.force_limit_biased  <= wlcm_pkg::FORCE_LIMIT_BIASED_RST;
         cfg_ff.torque_limit_biased <= wlcm_pkg::TORQUE_LIMIT_BIASED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/wrench_limit_cancel_monitor.sv
// A word accepted on the req_ port passes through the input, square and result registers to the rsp_ port.
// Throughput: one word per cycle while rsp_stall is low; three register stages (input, squares, result)
// advance independently, so bubbles close up while the output is stalled.
// Reset (synchronous, active high) empties the pipeline, reloads both cancel counters
// and returns every limit register to its default value.
module wrench_limit_cancel_monitor #(
   parameter int unsigned BURST_LEN = 10,
   parameter int unsigned QUIET_LEN = 100
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [wlcm_pkg::COMP_W-1:0]  req_force_x,
   input  logic signed [wlcm_pkg::COMP_W-1:0]  req_force_y,
   input  logic signed [wlcm_pkg::COMP_W-1:0]  req_force_z,
   input  logic signed [wlcm_pkg::COMP_W-1:0]  req_torque_x,
   input  logic signed [wlcm_pkg::COMP_W-1:0]  req_torque_y,
   input  logic signed [wlcm_pkg::COMP_W-1:0]  req_torque_z,
   input  logic                                req_bias_just_set,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_cancel,
   output logic                                rsp_limit_exceeded,
   output logic                                rsp_force_over,
   output logic                                rsp_torque_over,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wlcm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wlcm_pkg::LIMIT_W-1:0]        csr_data
);

   localparam logic [wlcm_pkg::CNT_W-1:0] BURST_RELOAD = wlcm_pkg::CNT_W'(BURST_LEN);
   localparam logic [wlcm_pkg::CNT_W-1:0] QUIET_RELOAD = wlcm_pkg::CNT_W'(QUIET_LEN);

   wlcm_pkg::cfg_type cfg;

   wlcm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Handshake for the three stages.
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic c_valid_ff, c_valid_in;
   logic a_ready, b_ready, c_ready;
   logic a_load, b_load, c_load;

   assign c_ready   = !c_valid_ff || !rsp_stall;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_stall = !a_ready;

   assign a_load = req_valid && a_ready;
   assign b_load = a_valid_ff && b_ready;
   assign c_load = b_valid_ff && c_ready;

   assign a_valid_in = a_ready ? req_valid  : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   // Input stage.
   logic signed [wlcm_pkg::COMP_W-1:0] a_comp_ff [wlcm_pkg::NUM_COMP];
   logic                               a_just_set_ff;

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_comp_ff[0]  <= req_force_x;
         a_comp_ff[1]  <= req_force_y;
         a_comp_ff[2]  <= req_force_z;
         a_comp_ff[3]  <= req_torque_x;
         a_comp_ff[4]  <= req_torque_y;
         a_comp_ff[5]  <= req_torque_z;
         a_just_set_ff <= req_bias_just_set;
      end
   end

   // Square stage: one multiplier per component and one per selected limit.
   logic [wlcm_pkg::COMP_W-1:0]   a_mag      [wlcm_pkg::NUM_COMP];
   logic [wlcm_pkg::SQ_W-1:0]     b_sq_in    [wlcm_pkg::NUM_COMP];
   logic [wlcm_pkg::SQ_W-1:0]     b_sq_ff    [wlcm_pkg::NUM_COMP];
   logic [wlcm_pkg::LIMIT_W-1:0]  a_flim, a_tlim;
   logic [wlcm_pkg::LIM_SQ_W-1:0] b_flim_sq_in, b_tlim_sq_in;
   logic [wlcm_pkg::LIM_SQ_W-1:0] b_flim_sq_ff, b_tlim_sq_ff;

   always_comb begin
      for (int i = 0; i < wlcm_pkg::NUM_COMP; i++) begin
         // The most negative value negates to 2^23, which still fits as unsigned.
         a_mag[i]   = a_comp_ff[i][wlcm_pkg::COMP_W-1] ? wlcm_pkg::COMP_W'(-a_comp_ff[i])
                                                        : wlcm_pkg::COMP_W'(a_comp_ff[i]);
         b_sq_in[i] = wlcm_pkg::SQ_W'(a_mag[i]) * wlcm_pkg::SQ_W'(a_mag[i]);
      end
   end

   // The first sample after a new bias is judged against the user limits.
   always_comb begin
      if (cfg.bias_enabled && !a_just_set_ff) begin
         a_flim = cfg.force_limit_biased;
         a_tlim = cfg.torque_limit_biased;
      end else begin
         a_flim = cfg.force_limit_user;
         a_tlim = cfg.torque_limit_user;
      end
      b_flim_sq_in = wlcm_pkg::LIM_SQ_W'(a_flim) * wlcm_pkg::LIM_SQ_W'(a_flim);
      b_tlim_sq_in = wlcm_pkg::LIM_SQ_W'(a_tlim) * wlcm_pkg::LIM_SQ_W'(a_tlim);
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_sq_ff      <= b_sq_in;
         b_flim_sq_ff <= b_flim_sq_in;
         b_tlim_sq_ff <= b_tlim_sq_in;
      end
   end

   // Result stage: sum, compare and the burst/quiet counters.
   logic [wlcm_pkg::SQ_W-1:0]  b_f2, b_t2;
   logic                       b_f_over, b_t_over, b_exceeded;
   logic [wlcm_pkg::CNT_W-1:0] burst_left_ff, burst_left_in;
   logic [wlcm_pkg::CNT_W-1:0] quiet_left_ff, quiet_left_in;
   logic                       cancel_in;
   logic                       c_cancel_ff, c_exceeded_ff, c_f_over_ff, c_t_over_ff;

   // Three squares of at most 2^46 each cannot carry out of 48 bits.
   assign b_f2       = b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
   assign b_t2       = b_sq_ff[3] + b_sq_ff[4] + b_sq_ff[5];
   assign b_f_over   = b_f2 > wlcm_pkg::SQ_W'(b_flim_sq_ff);
   assign b_t_over   = b_t2 > wlcm_pkg::SQ_W'(b_tlim_sq_ff);
   assign b_exceeded = b_f_over || b_t_over;

   always_comb begin
      burst_left_in = burst_left_ff;
      quiet_left_in = quiet_left_ff;
      cancel_in     = 1'b0;
      if (b_exceeded) begin
         // A counter that is zero or above its reload length counts as spent.
         if (burst_left_ff != '0 && burst_left_ff <= BURST_RELOAD) begin
            cancel_in     = 1'b1;
            burst_left_in = burst_left_ff - 1'b1;
         end else if (quiet_left_ff != '0 && quiet_left_ff <= QUIET_RELOAD) begin
            quiet_left_in = quiet_left_ff - 1'b1;
         end else begin
            burst_left_in = BURST_RELOAD;
            quiet_left_in = QUIET_RELOAD;
         end
      end else begin
         burst_left_in = BURST_RELOAD;
         quiet_left_in = QUIET_RELOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         burst_left_ff <= BURST_RELOAD;
         quiet_left_ff <= QUIET_RELOAD;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         if (c_load) begin
            burst_left_ff <= burst_left_in;
            quiet_left_ff <= quiet_left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         c_cancel_ff   <= cancel_in;
         c_exceeded_ff <= b_exceeded;
         c_f_over_ff   <= b_f_over;
         c_t_over_ff   <= b_t_over;
      end
   end

   assign rsp_valid          = c_valid_ff;
   assign rsp_cancel         = c_cancel_ff;
   assign rsp_limit_exceeded = c_exceeded_ff;
   assign rsp_force_over     = c_f_over_ff;
   assign rsp_torque_over    = c_t_over_ff;

endmodule
